### src/random_walk_distance_statistics_assert.svh
// assertion macros for the random walk statistics checker
`ifndef RANDOM_WALK_DISTANCE_STATISTICS_ASSERT_SVH
`define RANDOM_WALK_DISTANCE_STATISTICS_ASSERT_SVH

// condition in one cycle implies a property in the next
`define RWDS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rwds check failed");

// condition implies a property in the same cycle
`define RWDS_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rwds check failed");

`endif

### src/rwds_pkg.sv
// shared constants, types and tables of the random walk statistics block
`default_nettype none
package rwds_pkg;

    localparam int MAX_STEPS       = 128;
    localparam int STEP_W          = $clog2(MAX_STEPS);
    localparam int FRAC_BITS       = 16;
    localparam int WALK_COUNT_BITS = 20;
    localparam int SUM_BITS        = 24 + WALK_COUNT_BITS;
    localparam int SQ_SUM_BITS     = 30 + WALK_COUNT_BITS;
    localparam int SPW_W           = 8;
    localparam int WLK_W           = 21;
    localparam int CFG_W           = 21;
    localparam int OUT_W           = 24;
    localparam int COS_W           = 16;
    localparam int PHASE_W         = 16;
    localparam int POS_W           = 25;
    localparam int DIST_W          = 25;
    localparam int ROT_ITERS       = 28;
    localparam int ROT_ITER_W      = 5;
    localparam int ROT_SHIFT       = 30 - FRAC_BITS;
    localparam int CX_W            = 34;
    localparam int CZ_W            = 33;
    localparam int CNT_W           = 6;

    localparam logic [SPW_W-1:0] SPW_RESET = 8'd100;
    localparam logic [WLK_W-1:0] WLK_RESET = 21'd10000;
    localparam logic [SPW_W-1:0] SPW_MAX   = SPW_W'(MAX_STEPS);

    localparam logic signed [POS_W:0] POS_LIM = (POS_W+1)'(2 * MAX_STEPS * (2 ** FRAC_BITS) - 1);

    localparam logic signed [CX_W-1:0] ROT_GAIN  = 34'sd652032874;
    localparam logic signed [CZ_W-1:0] Z_QUARTER = 33'sd1073741824;
    localparam logic signed [CZ_W-1:0] Z_HALF    = 33'sd2147483648;

    localparam logic [CNT_W-1:0] SQRT_LAST = 6'd31;
    localparam logic [CNT_W-1:0] DIV_LAST  = 6'd63;
    localparam logic [CNT_W-1:0] ROT_LAST  = CNT_W'(ROT_ITERS - 1);

    typedef enum logic [0:0] {
        CFG_STEPS_PER_WALK = 1'b0,
        CFG_WALKS_COUNT    = 1'b1
    } t_cfg_idx;

    typedef enum logic [0:0] {
        ACT_WALK   = 1'b0,
        ACT_REPORT = 1'b1
    } t_action;

    typedef struct packed {
        logic [SQ_SUM_BITS-1:0] sq;
        logic [SUM_BITS-1:0]    sum;
    } t_entry;

    typedef enum logic [26:0] {
        ST_IDLE   = 27'd1 << 0,
        ST_W_ASQ  = 27'd1 << 1,
        ST_W_RAD  = 27'd1 << 2,
        ST_W_RSQ  = 27'd1 << 3,
        ST_W_ROT  = 27'd1 << 4,
        ST_W_MX   = 27'd1 << 5,
        ST_W_MY   = 27'd1 << 6,
        ST_W_MYW  = 27'd1 << 7,
        ST_W_POS  = 27'd1 << 8,
        ST_W_Q0   = 27'd1 << 9,
        ST_W_Q1   = 27'd1 << 10,
        ST_W_Q2   = 27'd1 << 11,
        ST_W_Q3   = 27'd1 << 12,
        ST_W_Q4   = 27'd1 << 13,
        ST_W_DSQ  = 27'd1 << 14,
        ST_W_DM   = 27'd1 << 15,
        ST_W_DW   = 27'd1 << 16,
        ST_W_UPD  = 27'd1 << 17,
        ST_R_RD   = 27'd1 << 18,
        ST_R_LD   = 27'd1 << 19,
        ST_R_DV1  = 27'd1 << 20,
        ST_R_DV2  = 27'd1 << 21,
        ST_R_MW   = 27'd1 << 22,
        ST_R_DIFF = 27'd1 << 23,
        ST_R_DV3  = 27'd1 << 24,
        ST_R_SQ   = 27'd1 << 25,
        ST_R_PUT  = 27'd1 << 26
    } t_state;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic signed [CZ_W-1:0] rot_arc(input logic [ROT_ITER_W-1:0] i);
        logic signed [CZ_W-1:0] a;
        case (i)
            5'd0:    a = 33'sd536870912;
            5'd1:    a = 33'sd316933406;
            5'd2:    a = 33'sd167458907;
            5'd3:    a = 33'sd85004756;
            5'd4:    a = 33'sd42667331;
            5'd5:    a = 33'sd21354465;
            5'd6:    a = 33'sd10679838;
            5'd7:    a = 33'sd5340245;
            5'd8:    a = 33'sd2670163;
            5'd9:    a = 33'sd1335087;
            5'd10:   a = 33'sd667544;
            5'd11:   a = 33'sd333772;
            5'd12:   a = 33'sd166886;
            5'd13:   a = 33'sd83443;
            5'd14:   a = 33'sd41722;
            5'd15:   a = 33'sd20861;
            5'd16:   a = 33'sd10430;
            5'd17:   a = 33'sd5215;
            5'd18:   a = 33'sd2608;
            5'd19:   a = 33'sd1304;
            5'd20:   a = 33'sd652;
            5'd21:   a = 33'sd326;
            5'd22:   a = 33'sd163;
            5'd23:   a = 33'sd81;
            5'd24:   a = 33'sd41;
            5'd25:   a = 33'sd20;
            5'd26:   a = 33'sd10;
            5'd27:   a = 33'sd5;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

### src/rwds_req_if.sv
// request channel of the random walk statistics block
`default_nettype none
interface rwds_req_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic signed [rwds_pkg::COS_W-1:0]   polar_cosine;
    logic [rwds_pkg::PHASE_W-1:0]        azimuth_phase;
    logic [rwds_pkg::STEP_W-1:0]         report_step;

    modport source (output valid, action, polar_cosine, azimuth_phase, report_step,
                    input ready);
    modport sink (input valid, action, polar_cosine, azimuth_phase, report_step,
                  output ready);
endinterface
`default_nettype wire

### src/rwds_res_if.sv
// result channel of the random walk statistics block
`default_nettype none
interface rwds_res_if;
    logic                          valid;
    logic                          ready;
    logic [rwds_pkg::STEP_W-1:0]   step_echo;
    logic [rwds_pkg::OUT_W-1:0]    mean_distance;
    logic [rwds_pkg::OUT_W-1:0]    distance_uncertainty;

    modport source (output valid, step_echo, mean_distance, distance_uncertainty,
                    input ready);
    modport sink (input valid, step_echo, mean_distance, distance_uncertainty,
                  output ready);
endinterface
`default_nettype wire

### src/random_walk_distance_statistics.sv
// 3d random walk with per-step distance sums and mean/uncertainty reports
// walk step: request to next ready is dominated by two bit-pair square roots and a
//   28-iteration cordic rotation; no result
// report: request to result is dominated by three bit-serial divisions and one square
//   root; result register frees the request side
// reset: synchronous active low; sum store entries read as zero via valid flops,
//   no clearing pass; config resets to 100 steps and 10000 walks
`default_nettype none
module random_walk_distance_statistics (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_idx,
    input  logic [rwds_pkg::CFG_W-1:0]    i_cfg_data,
    rwds_req_if.sink                      i_req,
    rwds_res_if.source                    o_res
);

    // control state
    rwds_pkg::t_state                     r_state, n_state;
    logic [rwds_pkg::SPW_W-1:0]           r_spw;
    logic [rwds_pkg::WLK_W-1:0]           r_walks;
    logic signed [rwds_pkg::POS_W-1:0]    r_px, n_px, r_py, n_py, r_pz, n_pz;
    logic [rwds_pkg::STEP_W-1:0]          r_step, n_step;
    logic [rwds_pkg::MAX_STEPS-1:0]       r_valid;
    logic                                 r_ov, n_ov;

    // payload and datapath
    logic [rwds_pkg::STEP_W-1:0]          r_k, n_k;
    logic signed [rwds_pkg::COS_W-1:0]    r_cos, n_cos;
    logic [rwds_pkg::PHASE_W-1:0]         r_phase, n_phase;
    rwds_pkg::t_entry                     r_mem [rwds_pkg::MAX_STEPS];
    rwds_pkg::t_entry                     r_rd;
    logic                                 r_rd_vld;
    logic [31:0]                          r_ma, n_ma, r_mb, n_mb;
    logic [63:0]                          r_mp;
    logic [63:0]                          r_sv, n_sv;
    logic [33:0]                          r_srem, n_srem;
    logic [31:0]                          r_sroot, n_sroot;
    logic [63:0]                          r_dv, n_dv;
    logic [rwds_pkg::WLK_W-1:0]           r_drem, n_drem, r_dd, n_dd;
    logic signed [rwds_pkg::CX_W-1:0]     r_cx, n_cx, r_cy, n_cy;
    logic signed [rwds_pkg::CZ_W-1:0]     r_cz, n_cz;
    logic                                 r_flip, n_flip;
    logic [rwds_pkg::CNT_W-1:0]           r_cnt, n_cnt;
    logic                                 r_cneg, n_cneg, r_sneg, n_sneg;
    logic signed [20:0]                   r_dx, n_dx;
    logic [63:0]                          r_acc, n_acc;
    logic [rwds_pkg::SUM_BITS-1:0]        r_mean, n_mean;
    logic [rwds_pkg::SQ_SUM_BITS-1:0]     r_msq, n_msq;
    logic [rwds_pkg::STEP_W-1:0]          r_o_step, n_o_step;
    logic [rwds_pkg::OUT_W-1:0]           r_o_mean, n_o_mean, r_o_unc, n_o_unc;

    // combinational helpers
    logic                                 s_in_acc;
    logic [rwds_pkg::SPW_W-1:0]           s_eff;
    logic [rwds_pkg::SPW_W-1:0]           s_stp1;
    logic [rwds_pkg::WLK_W-1:0]           s_n;
    rwds_pkg::t_entry                     s_ent, s_wr_ent;
    logic                                 s_mem_we;
    logic [35:0]                          s_rem2, s_trial;
    logic                                 s_sge;
    logic [33:0]                          s_srem_nx;
    logic [31:0]                          s_sroot_nx;
    logic [63:0]                          s_sv_nx;
    logic [21:0]                          s_dt;
    logic                                 s_dge;
    logic [rwds_pkg::WLK_W-1:0]           s_drem_nx;
    logic [63:0]                          s_dv_nx;
    logic signed [rwds_pkg::CX_W-1:0]     s_xs, s_ys, s_cx_nx, s_cy_nx;
    logic signed [rwds_pkg::CZ_W-1:0]     s_cz_nx, s_arc, s_zp, s_z0;
    logic                                 s_flip0;
    logic signed [rwds_pkg::CX_W-1:0]     s_c, s_s;
    logic signed [19:0]                   s_cs, s_sn, s_cmag, s_smag;
    logic signed [16:0]                   s_a17;
    logic [15:0]                          s_amag;
    logic [32:0]                          s_rad;
    logic                                 s_negsel;
    logic signed [36:0]                   s_pd;
    logic signed [20:0]                   s_dd;
    logic signed [rwds_pkg::POS_W:0]      s_sx, s_sy, s_sz;
    logic [rwds_pkg::SUM_BITS:0]          s_sum_w;
    logic [rwds_pkg::SQ_SUM_BITS:0]       s_sq_w;
    logic [63:0]                          s_m2, s_q2, s_diff;

    // position saturation
    function automatic logic signed [rwds_pkg::POS_W-1:0] clamp_pos(
        input logic signed [rwds_pkg::POS_W:0] v);
        logic signed [rwds_pkg::POS_W:0] t;
        if (v > rwds_pkg::POS_LIM) begin
            t = rwds_pkg::POS_LIM;
        end else if (v < -rwds_pkg::POS_LIM) begin
            t = -rwds_pkg::POS_LIM;
        end else begin
            t = v;
        end
        return t[rwds_pkg::POS_W-1:0];
    endfunction

    // magnitude of a position coordinate
    function automatic logic [rwds_pkg::POS_W-2:0] pos_mag(
        input logic signed [rwds_pkg::POS_W-1:0] v);
        logic signed [rwds_pkg::POS_W-1:0] t;
        t = v[rwds_pkg::POS_W-1] ? -v : v;
        return t[rwds_pkg::POS_W-2:0];
    endfunction

    assign s_in_acc    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == rwds_pkg::ST_IDLE);

    assign o_res.valid                = r_ov;
    assign o_res.step_echo            = r_o_step;
    assign o_res.mean_distance        = r_o_mean;
    assign o_res.distance_uncertainty = r_o_unc;

    // effective step count and walk divisor
    always_comb begin
        if (r_spw == '0) begin
            s_eff = 8'd1;
        end else if (r_spw > rwds_pkg::SPW_MAX) begin
            s_eff = rwds_pkg::SPW_MAX;
        end else begin
            s_eff = r_spw;
        end
        s_n    = (r_walks < 21'd2) ? 21'd2 : r_walks;
        s_stp1 = {1'b0, r_step} + 8'd1;
        s_ent  = r_rd_vld ? r_rd : '0;
    end

    // square root, two radicand bits per cycle
    always_comb begin
        s_rem2     = {r_srem, r_sv[63:62]};
        s_trial    = {2'b00, r_sroot, 2'b01};
        s_sge      = (s_rem2 >= s_trial);
        s_srem_nx  = s_sge ? 34'(s_rem2 - s_trial) : s_rem2[33:0];
        s_sroot_nx = {r_sroot[30:0], s_sge};
        s_sv_nx    = {r_sv[61:0], 2'b00};
    end

    // restoring division, one quotient bit per cycle
    always_comb begin
        s_dt      = {r_drem, r_dv[63]};
        s_dge     = (s_dt >= {1'b0, r_dd});
        s_drem_nx = s_dge ? 21'(s_dt - {1'b0, r_dd}) : s_dt[20:0];
        s_dv_nx   = {r_dv[62:0], s_dge};
    end

    // cordic rotation, one iteration per cycle
    always_comb begin
        s_arc = rwds_pkg::rot_arc(r_cnt[rwds_pkg::ROT_ITER_W-1:0]);
        s_xs  = r_cx >>> r_cnt[rwds_pkg::ROT_ITER_W-1:0];
        s_ys  = r_cy >>> r_cnt[rwds_pkg::ROT_ITER_W-1:0];
        if (!r_cz[rwds_pkg::CZ_W-1]) begin
            s_cx_nx = r_cx - s_ys;
            s_cy_nx = r_cy + s_xs;
            s_cz_nx = r_cz - s_arc;
        end else begin
            s_cx_nx = r_cx + s_ys;
            s_cy_nx = r_cy - s_xs;
            s_cz_nx = r_cz + s_arc;
        end
    end

    // phase fold into the right half plane
    always_comb begin
        s_zp    = {r_phase[15], r_phase, 16'b0};
        s_z0    = s_zp;
        s_flip0 = 1'b0;
        if (s_zp > rwds_pkg::Z_QUARTER) begin
            s_z0    = s_zp - rwds_pkg::Z_HALF;
            s_flip0 = 1'b1;
        end else if (s_zp < -rwds_pkg::Z_QUARTER) begin
            s_z0    = s_zp + rwds_pkg::Z_HALF;
            s_flip0 = 1'b1;
        end
    end

    // cosine, sine and step geometry
    always_comb begin
        s_c    = r_flip ? -r_cx : r_cx;
        s_s    = r_flip ? -r_cy : r_cy;
        s_cs   = 20'(s_c >>> rwds_pkg::ROT_SHIFT);
        s_sn   = 20'(s_s >>> rwds_pkg::ROT_SHIFT);
        s_cmag = s_cs[19] ? -s_cs : s_cs;
        s_smag = s_sn[19] ? -s_sn : s_sn;
        s_a17  = i_req.polar_cosine[15] ? -17'(i_req.polar_cosine) : 17'(i_req.polar_cosine);
        s_amag = s_a17[15:0];
        s_rad  = {31'(31'd1 << 30) - r_mp[30:0], 2'b00};
        s_negsel = (r_state == rwds_pkg::ST_W_POS) ? r_sneg : r_cneg;
        s_pd   = s_negsel ? -$signed({1'b0, r_mp[35:0]}) : $signed({1'b0, r_mp[35:0]});
        s_dd   = 21'(s_pd >>> rwds_pkg::FRAC_BITS);
        s_sx   = {r_px[rwds_pkg::POS_W-1], r_px} + 26'(r_dx);
        s_sy   = {r_py[rwds_pkg::POS_W-1], r_py} + 26'(s_dd);
        s_sz   = {r_pz[rwds_pkg::POS_W-1], r_pz} + 26'($signed({r_cos, 1'b0}));
    end

    // sum update and variance term
    always_comb begin
        s_sum_w = {1'b0, s_ent.sum} + {20'b0, r_sroot[rwds_pkg::DIST_W-1:0]};
        s_sq_w  = {1'b0, s_ent.sq} + {17'b0, r_mp[49:16]};
        s_wr_ent.sum = s_sum_w[rwds_pkg::SUM_BITS] ? '1 : s_sum_w[rwds_pkg::SUM_BITS-1:0];
        s_wr_ent.sq  = s_sq_w[rwds_pkg::SQ_SUM_BITS] ? '1 :
                       s_sq_w[rwds_pkg::SQ_SUM_BITS-1:0];
        s_mem_we = (r_state == rwds_pkg::ST_W_UPD);
        s_m2   = (|r_mean[rwds_pkg::SUM_BITS-1:32]) ? '1 : r_mp;
        s_q2   = (|r_msq[rwds_pkg::SQ_SUM_BITS-1:48]) ? '1 : {r_msq[47:0], 16'b0};
        s_diff = (s_q2 > s_m2) ? (s_q2 - s_m2) : '0;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_px = r_px;  n_py = r_py;  n_pz = r_pz;
        n_step = r_step;  n_k = r_k;
        n_cos = r_cos;  n_phase = r_phase;
        n_ma = r_ma;  n_mb = r_mb;
        n_sv = r_sv;  n_srem = r_srem;  n_sroot = r_sroot;
        n_dv = r_dv;  n_drem = r_drem;  n_dd = r_dd;
        n_cx = r_cx;  n_cy = r_cy;  n_cz = r_cz;  n_flip = r_flip;
        n_cnt = r_cnt;  n_cneg = r_cneg;  n_sneg = r_sneg;  n_dx = r_dx;
        n_acc = r_acc;  n_mean = r_mean;  n_msq = r_msq;
        n_ov = r_ov && !o_res.ready;
        n_o_step = r_o_step;  n_o_mean = r_o_mean;  n_o_unc = r_o_unc;
        case (r_state)
            rwds_pkg::ST_IDLE: begin
                if (s_in_acc) begin
                    n_cos   = i_req.polar_cosine;
                    n_phase = i_req.azimuth_phase;
                    n_ma    = {16'b0, s_amag};
                    n_mb    = {16'b0, s_amag};
                    if (i_req.action == rwds_pkg::ACT_REPORT) begin
                        n_k     = i_req.report_step;
                        n_state = rwds_pkg::ST_R_RD;
                    end else begin
                        n_k     = r_step;
                        n_state = rwds_pkg::ST_W_ASQ;
                        if ({1'b0, r_step} >= s_eff) begin
                            n_px = '0;  n_py = '0;  n_pz = '0;
                            n_step = '0;  n_k = '0;
                        end
                    end
                end
            end
            rwds_pkg::ST_W_ASQ: n_state = rwds_pkg::ST_W_RAD;
            rwds_pkg::ST_W_RAD: begin
                n_sv = {31'b0, s_rad};  n_srem = '0;  n_sroot = '0;  n_cnt = '0;
                n_state = rwds_pkg::ST_W_RSQ;
            end
            rwds_pkg::ST_W_RSQ: begin
                n_sv = s_sv_nx;  n_srem = s_srem_nx;  n_sroot = s_sroot_nx;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == rwds_pkg::SQRT_LAST) begin
                    n_cx = rwds_pkg::ROT_GAIN;  n_cy = '0;  n_cz = s_z0;
                    n_flip = s_flip0;  n_cnt = '0;
                    n_state = rwds_pkg::ST_W_ROT;
                end
            end
            rwds_pkg::ST_W_ROT: begin
                n_cx = s_cx_nx;  n_cy = s_cy_nx;  n_cz = s_cz_nx;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == rwds_pkg::ROT_LAST) begin
                    n_state = rwds_pkg::ST_W_MX;
                end
            end
            rwds_pkg::ST_W_MX: begin
                n_ma = {15'b0, r_sroot[16:0]};
                n_mb = {12'b0, s_cmag};
                n_cneg = s_cs[19];
                n_state = rwds_pkg::ST_W_MY;
            end
            rwds_pkg::ST_W_MY: begin
                n_mb = {12'b0, s_smag};
                n_sneg = s_sn[19];
                n_state = rwds_pkg::ST_W_MYW;
            end
            rwds_pkg::ST_W_MYW: begin
                n_dx = s_dd;
                n_state = rwds_pkg::ST_W_POS;
            end
            rwds_pkg::ST_W_POS: begin
                n_px = clamp_pos(s_sx);
                n_py = clamp_pos(s_sy);
                n_pz = clamp_pos(s_sz);
                n_state = rwds_pkg::ST_W_Q0;
            end
            rwds_pkg::ST_W_Q0: begin
                n_ma = {8'b0, pos_mag(r_px)};  n_mb = {8'b0, pos_mag(r_px)};
                n_state = rwds_pkg::ST_W_Q1;
            end
            rwds_pkg::ST_W_Q1: begin
                n_ma = {8'b0, pos_mag(r_py)};  n_mb = {8'b0, pos_mag(r_py)};
                n_state = rwds_pkg::ST_W_Q2;
            end
            rwds_pkg::ST_W_Q2: begin
                n_ma = {8'b0, pos_mag(r_pz)};  n_mb = {8'b0, pos_mag(r_pz)};
                n_acc = r_mp;
                n_state = rwds_pkg::ST_W_Q3;
            end
            rwds_pkg::ST_W_Q3: begin
                n_acc = r_acc + r_mp;
                n_state = rwds_pkg::ST_W_Q4;
            end
            rwds_pkg::ST_W_Q4: begin
                n_sv = r_acc + r_mp;  n_srem = '0;  n_sroot = '0;  n_cnt = '0;
                n_state = rwds_pkg::ST_W_DSQ;
            end
            rwds_pkg::ST_W_DSQ: begin
                n_sv = s_sv_nx;  n_srem = s_srem_nx;  n_sroot = s_sroot_nx;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == rwds_pkg::SQRT_LAST) begin
                    n_state = rwds_pkg::ST_W_DM;
                end
            end
            rwds_pkg::ST_W_DM: begin
                n_ma = {7'b0, r_sroot[rwds_pkg::DIST_W-1:0]};
                n_mb = {7'b0, r_sroot[rwds_pkg::DIST_W-1:0]};
                n_state = rwds_pkg::ST_W_DW;
            end
            rwds_pkg::ST_W_DW: n_state = rwds_pkg::ST_W_UPD;
            rwds_pkg::ST_W_UPD: begin
                if (s_stp1 >= s_eff) begin
                    n_px = '0;  n_py = '0;  n_pz = '0;  n_step = '0;
                end else begin
                    n_step = s_stp1[rwds_pkg::STEP_W-1:0];
                end
                n_state = rwds_pkg::ST_IDLE;
            end
            rwds_pkg::ST_R_RD: n_state = rwds_pkg::ST_R_LD;
            rwds_pkg::ST_R_LD: begin
                n_dv = {20'b0, s_ent.sum};  n_drem = '0;  n_dd = s_n;  n_cnt = '0;
                n_state = rwds_pkg::ST_R_DV1;
            end
            rwds_pkg::ST_R_DV1: begin
                n_dv = s_dv_nx;  n_drem = s_drem_nx;  n_cnt = r_cnt + 6'd1;
                if (r_cnt == rwds_pkg::DIV_LAST) begin
                    n_mean = s_dv_nx[rwds_pkg::SUM_BITS-1:0];
                    n_dv = {14'b0, s_ent.sq};  n_drem = '0;  n_cnt = '0;
                    n_state = rwds_pkg::ST_R_DV2;
                end
            end
            rwds_pkg::ST_R_DV2: begin
                n_dv = s_dv_nx;  n_drem = s_drem_nx;  n_cnt = r_cnt + 6'd1;
                if (r_cnt == rwds_pkg::DIV_LAST) begin
                    n_msq = s_dv_nx[rwds_pkg::SQ_SUM_BITS-1:0];
                    n_ma = r_mean[31:0];  n_mb = r_mean[31:0];
                    n_state = rwds_pkg::ST_R_MW;
                end
            end
            rwds_pkg::ST_R_MW: n_state = rwds_pkg::ST_R_DIFF;
            rwds_pkg::ST_R_DIFF: begin
                n_dv = s_diff;  n_drem = '0;  n_dd = s_n - 21'd1;  n_cnt = '0;
                n_state = rwds_pkg::ST_R_DV3;
            end
            rwds_pkg::ST_R_DV3: begin
                n_dv = s_dv_nx;  n_drem = s_drem_nx;  n_cnt = r_cnt + 6'd1;
                if (r_cnt == rwds_pkg::DIV_LAST) begin
                    n_sv = s_dv_nx;  n_srem = '0;  n_sroot = '0;  n_cnt = '0;
                    n_state = rwds_pkg::ST_R_SQ;
                end
            end
            rwds_pkg::ST_R_SQ: begin
                n_sv = s_sv_nx;  n_srem = s_srem_nx;  n_sroot = s_sroot_nx;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == rwds_pkg::SQRT_LAST) begin
                    n_state = rwds_pkg::ST_R_PUT;
                end
            end
            rwds_pkg::ST_R_PUT: begin
                // wait for the result register to free up
                if (!r_ov || o_res.ready) begin
                    n_ov = 1'b1;
                    n_o_step = r_k;
                    n_o_mean = (|r_mean[rwds_pkg::SUM_BITS-1:rwds_pkg::OUT_W]) ? '1 :
                               r_mean[rwds_pkg::OUT_W-1:0];
                    n_o_unc  = (|r_sroot[31:rwds_pkg::OUT_W]) ? '1 :
                               r_sroot[rwds_pkg::OUT_W-1:0];
                    n_state = rwds_pkg::ST_IDLE;
                end
            end
            default: n_state = rwds_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rwds_pkg::ST_IDLE;
            r_spw   <= rwds_pkg::SPW_RESET;
            r_walks <= rwds_pkg::WLK_RESET;
            r_px    <= '0;
            r_py    <= '0;
            r_pz    <= '0;
            r_step  <= '0;
            r_valid <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_px    <= n_px;
            r_py    <= n_py;
            r_pz    <= n_pz;
            r_step  <= n_step;
            r_ov    <= n_ov;
            if (s_mem_we) begin
                r_valid[r_k] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rwds_pkg::CFG_STEPS_PER_WALK: r_spw   <= i_cfg_data[rwds_pkg::SPW_W-1:0];
                    rwds_pkg::CFG_WALKS_COUNT:    r_walks <= i_cfg_data[rwds_pkg::WLK_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // sum store, registered read
    always_ff @(posedge i_clk) begin
        if (s_mem_we) begin
            r_mem[r_k] <= s_wr_ent;
        end
        r_rd     <= r_mem[r_k];
        r_rd_vld <= r_valid[r_k];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_cos    <= n_cos;
        r_phase  <= n_phase;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_mp     <= {32'b0, r_ma} * {32'b0, r_mb};
        r_sv     <= n_sv;
        r_srem   <= n_srem;
        r_sroot  <= n_sroot;
        r_dv     <= n_dv;
        r_drem   <= n_drem;
        r_dd     <= n_dd;
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_cz     <= n_cz;
        r_flip   <= n_flip;
        r_cnt    <= n_cnt;
        r_cneg   <= n_cneg;
        r_sneg   <= n_sneg;
        r_dx     <= n_dx;
        r_acc    <= n_acc;
        r_mean   <= n_mean;
        r_msq    <= n_msq;
        r_o_step <= n_o_step;
        r_o_mean <= n_o_mean;
        r_o_unc  <= n_o_unc;
    end

endmodule
`default_nettype wire

### src/rwds_checker.sv
// port-level checks of the random walk statistics block and their binding
`default_nettype none
`include "random_walk_distance_statistics_assert.svh"
module rwds_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_ready,
    input  logic                          i_req_action,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  logic [rwds_pkg::STEP_W-1:0]   i_res_step_echo,
    input  logic [rwds_pkg::OUT_W-1:0]    i_res_mean_distance,
    input  logic [rwds_pkg::OUT_W-1:0]    i_res_distance_uncertainty
);

    logic s_in_acc;
    logic s_res_stall;

    assign s_in_acc    = i_req_valid && i_req_ready;
    assign s_res_stall = i_res_valid && !i_res_ready;

    // a stalled result stays offered and unchanged
    `RWDS_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, s_res_stall, i_res_valid)
    `RWDS_ASSERT_NEXT(a_res_stable, i_clk, i_rst_n, s_res_stall, $stable(i_res_step_echo) && $stable(i_res_mean_distance) && $stable(i_res_distance_uncertainty))
    // one request at a time: busy after a request
    `RWDS_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, s_in_acc, !i_req_ready)
    // a walk step never raises a result
    `RWDS_ASSERT_NEXT(a_walk_silent, i_clk, i_rst_n, s_in_acc && (i_req_action == rwds_pkg::ACT_WALK), !$rose(i_res_valid))
    // a new result comes only out of a busy cycle
    `RWDS_ASSERT_NOW(a_res_from_busy, i_clk, i_rst_n, $rose(i_res_valid), !$past(i_req_ready))

endmodule

bind random_walk_distance_statistics rwds_checker u_rwds_checker (
    .i_clk                      (i_clk),
    .i_rst_n                    (i_rst_n),
    .i_req_valid                (i_req.valid),
    .i_req_ready                (i_req.ready),
    .i_req_action               (i_req.action),
    .i_res_valid                (o_res.valid),
    .i_res_ready                (o_res.ready),
    .i_res_step_echo            (o_res.step_echo),
    .i_res_mean_distance        (o_res.mean_distance),
    .i_res_distance_uncertainty (o_res.distance_uncertainty)
);
`default_nettype wire

### tb/tb_random_walk_distance_statistics.sv
// self-checking testbench of the random walk distance statistics block
`default_nettype none
module tb_random_walk_distance_statistics;

    // expected report result
    typedef struct packed {
        logic [rwds_pkg::STEP_W-1:0] step;
        logic [rwds_pkg::OUT_W-1:0]  mean;
        logic [rwds_pkg::OUT_W-1:0]  unc;
    } t_report;

    localparam longint ARC_TURN [28] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81,
        41, 20, 10, 5
    };
    localparam longint CORDIC_GAIN = 652032874;
    localparam longint COORD_LIM   =
        (longint'(2 * rwds_pkg::MAX_STEPS) << rwds_pkg::FRAC_BITS) - 1;
    localparam int     DRAIN_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [0:0] i_cfg_idx;
    logic [rwds_pkg::CFG_W-1:0] i_cfg_data;

    rwds_req_if req_ch ();
    rwds_res_if res_ch ();

    random_walk_distance_statistics u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch.sink),
        .o_res      (res_ch.source)
    );

    // shadow state of the walk and the per-step sums
    int unsigned    mdl_steps_cfg;
    int unsigned    mdl_walks_cfg;
    longint         walk_x, walk_y, walk_z;
    int unsigned    walk_index;
    logic [63:0]    dist_sum [rwds_pkg::MAX_STEPS];
    logic [63:0]    dist_sq_sum [rwds_pkg::MAX_STEPS];

    t_report        pending_reports [$];
    int             fail_count;
    int             mismatch_count;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #40000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_LIM) return COORD_LIM;
        if (v < -COORD_LIM) return -COORD_LIM;
        return v;
    endfunction

    // cordic rotation, cosine and sine in q.30
    task automatic cordic_rotate(input logic [15:0] ph, output longint c, output longint s);
        longint z, x, y, nx;
        bit     flip;
        z = longint'(ph) * 65536;
        x = CORDIC_GAIN;
        y = 0;
        flip = 1'b0;
        if (z >= (64'sd1 <<< 31)) z = z - (64'sd1 <<< 32);
        if (z > (64'sd1 <<< 30)) begin
            z = z - (64'sd1 <<< 31);
            flip = 1'b1;
        end else if (z < -(64'sd1 <<< 30)) begin
            z = z + (64'sd1 <<< 31);
            flip = 1'b1;
        end
        for (int i = 0; i < 28; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ARC_TURN[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ARC_TURN[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // advance the shadow walk by one step and accumulate the distance
    task automatic predict_step(input logic signed [15:0] cosv, input logic [15:0] ph);
        int unsigned eff;
        longint      a, r, cs, sn;
        logic [63:0] sq, d, lim;
        eff = mdl_steps_cfg;
        if (eff == 0) eff = 1;
        if (eff > rwds_pkg::MAX_STEPS) eff = rwds_pkg::MAX_STEPS;
        if (walk_index >= eff) begin
            walk_x = 0; walk_y = 0; walk_z = 0;
            walk_index = 0;
        end
        a = longint'(cosv);
        r = longint'(int_sqrt(64'((64'sd1 <<< 30) - a * a) << 2));
        cordic_rotate(ph, cs, sn);
        cs = cs >>> 14;
        sn = sn >>> 14;
        walk_x = clamp_coord(walk_x + ((r * cs) >>> rwds_pkg::FRAC_BITS));
        walk_y = clamp_coord(walk_y + ((r * sn) >>> rwds_pkg::FRAC_BITS));
        walk_z = clamp_coord(walk_z + (a <<< 1));
        sq = 64'(walk_x * walk_x) + 64'(walk_y * walk_y) + 64'(walk_z * walk_z);
        d = int_sqrt(sq);
        lim = (64'd1 << rwds_pkg::SUM_BITS) - 1;
        dist_sum[walk_index] = dist_sum[walk_index] + d;
        if (dist_sum[walk_index] > lim) dist_sum[walk_index] = lim;
        lim = (64'd1 << rwds_pkg::SQ_SUM_BITS) - 1;
        dist_sq_sum[walk_index] = dist_sq_sum[walk_index] + ((d * d) >> rwds_pkg::FRAC_BITS);
        if (dist_sq_sum[walk_index] > lim) dist_sq_sum[walk_index] = lim;
        walk_index++;
        if (walk_index >= eff) begin
            walk_x = 0; walk_y = 0; walk_z = 0;
            walk_index = 0;
        end
    endtask

    // mean distance and uncertainty of one step index
    function automatic t_report predict_report(input logic [rwds_pkg::STEP_W-1:0] k);
        t_report      res;
        logic [63:0]  n, mean, mean_sq, m2, q2, diff, unc;
        logic [127:0] wide;
        n = (mdl_walks_cfg < 2) ? 64'd2 : 64'(mdl_walks_cfg);
        mean = dist_sum[k] / n;
        mean_sq = dist_sq_sum[k] / n;
        wide = 128'(mean) * 128'(mean);
        m2 = (wide[127:64] != 0) ? '1 : wide[63:0];
        wide = 128'(mean_sq) << rwds_pkg::FRAC_BITS;
        q2 = (wide[127:64] != 0) ? '1 : wide[63:0];
        diff = (q2 > m2) ? q2 - m2 : 64'd0;
        unc = int_sqrt(diff / (n - 1));
        res.step = k;
        res.mean = (mean > 64'hFFFFFF) ? '1 : mean[rwds_pkg::OUT_W-1:0];
        res.unc = (unc > 64'hFFFFFF) ? '1 : unc[rwds_pkg::OUT_W-1:0];
        return res;
    endfunction

    // one request, predicted on acceptance
    task automatic send_request(input rwds_pkg::t_action act, input logic signed [15:0] cosv,
                                input logic [15:0] ph,
                                input logic [rwds_pkg::STEP_W-1:0] k);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
              ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.action <= act;
        req_ch.polar_cosine <= cosv;
        req_ch.azimuth_phase <= ph;
        req_ch.report_step <= k;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (act == rwds_pkg::ACT_WALK) predict_step(cosv, ph);
        else pending_reports.push_back(predict_report(k));
        @(negedge i_clk);
    endtask

    // wait for every report, then let a walk step in flight finish
    task automatic drain_block();
        req_ch.valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input rwds_pkg::t_cfg_idx idx,
                             input logic [rwds_pkg::CFG_W-1:0] val);
        drain_block();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == rwds_pkg::CFG_STEPS_PER_WALK) mdl_steps_cfg = val[rwds_pkg::SPW_W-1:0];
        else mdl_walks_cfg = val[rwds_pkg::WLK_W-1:0];
    endtask

    task automatic random_walk_step();
        send_request(rwds_pkg::ACT_WALK, 16'($urandom), 16'($urandom), 7'($urandom));
    endtask

    // result acceptance and comparison
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_reports.size() == 0) begin
                fail_count++;
                if (mismatch_count < 10)
                    $display("unexpected result step %0d", res_ch.step_echo);
                mismatch_count++;
            end else begin
                t_report exp_r;
                exp_r = pending_reports.pop_front();
                if (exp_r.step !== res_ch.step_echo || exp_r.mean !== res_ch.mean_distance
                    || exp_r.unc !== res_ch.distance_uncertainty) begin
                    fail_count++;
                    if (mismatch_count < 10)
                        $display("mismatch: exp step %0d mean %0d unc %0d, got %0d %0d %0d",
                                 exp_r.step, exp_r.mean, exp_r.unc, res_ch.step_echo,
                                 res_ch.mean_distance, res_ch.distance_uncertainty);
                    mismatch_count++;
                end
            end
        end
    end

    // result side stalls: mostly ready, short and occasional long stalls
    int stall_left;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60)
                                                      : $urandom_range(0, 3);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // extremes of direction and phase, reports at both ends of the store
    task automatic test_directed_fields();
        logic [15:0] phases [8];
        phases = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
                   16'h3FFF, 16'h4001, 16'h7FFF};
        write_reg(rwds_pkg::CFG_STEPS_PER_WALK, 21'd4);
        write_reg(rwds_pkg::CFG_WALKS_COUNT, 21'd2);
        for (int i = 0; i < 8; i++)
            send_request(rwds_pkg::ACT_WALK, (i % 3 == 0) ? 16'sh8000 :
                                   ((i % 3 == 1) ? 16'sd32767 : 16'sd0), phases[i], 7'd0);
        send_request(rwds_pkg::ACT_REPORT, 16'sd0, 16'h0, 7'd0);
        send_request(rwds_pkg::ACT_REPORT, 16'sd0, 16'h0, 7'd3);
        send_request(rwds_pkg::ACT_REPORT, 16'sd0, 16'h0, 7'd127);
    endtask

    // out of range step and walk counts, change of step count mid walk
    task automatic test_config_extremes();
        write_reg(rwds_pkg::CFG_STEPS_PER_WALK, 21'd0);
        write_reg(rwds_pkg::CFG_WALKS_COUNT, 21'd0);
        repeat (3) random_walk_step();
        send_request(rwds_pkg::ACT_REPORT, 16'sd0, 16'h0, 7'd0);
        write_reg(rwds_pkg::CFG_WALKS_COUNT, 21'd1);
        send_request(rwds_pkg::ACT_REPORT, 16'sd0, 16'h0, 7'd1);
        write_reg(rwds_pkg::CFG_STEPS_PER_WALK, 21'd10);
        repeat (5) random_walk_step();
        write_reg(rwds_pkg::CFG_STEPS_PER_WALK, 21'd3);
        repeat (2) random_walk_step();
        send_request(rwds_pkg::ACT_REPORT, 16'sd0, 16'h0, 7'd0);
        write_reg(rwds_pkg::CFG_WALKS_COUNT, 21'h1FFFFF);
        send_request(rwds_pkg::ACT_REPORT, 16'sd0, 16'h0, 7'd0);
        write_reg(rwds_pkg::CFG_STEPS_PER_WALK, 21'hFF);
        repeat (130) random_walk_step();
        write_reg(rwds_pkg::CFG_WALKS_COUNT, 21'd2);
        send_request(rwds_pkg::ACT_REPORT, 16'sd0, 16'h0, 7'd127);
        send_request(rwds_pkg::ACT_REPORT, 16'sd0, 16'h0, 7'd126);
        write_reg(rwds_pkg::CFG_STEPS_PER_WALK, 21'd128);
        send_request(rwds_pkg::ACT_WALK, 16'sd100, 16'h1234, 7'd0);
    endtask

    // whole walks with random content, then reports; some noise in between
    task automatic test_random_walks();
        int steps, walks;
        for (int ph = 0; ph < 26; ph++) begin
            steps = $urandom_range(1, 8);
            walks = $urandom_range(2, 30);
            write_reg(rwds_pkg::CFG_STEPS_PER_WALK, 21'(steps));
            write_reg(rwds_pkg::CFG_WALKS_COUNT, 21'(walks));
            repeat ($urandom_range(3, 6) * steps) begin
                if ($urandom_range(0, 9) == 0)
                    send_request(rwds_pkg::ACT_REPORT, 16'($urandom), 16'($urandom),
                                 7'($urandom));
                else
                    random_walk_step();
            end
            for (int k = 0; k < steps; k++)
                send_request(rwds_pkg::ACT_REPORT, 16'($urandom), 16'($urandom), 7'(k));
            send_request(rwds_pkg::ACT_REPORT, 16'($urandom), 16'($urandom), 7'($urandom));
        end
    endtask

    // sender holds off until every report is back, then resumes
    task automatic test_pressure_holdoff();
        repeat (4) random_walk_step();
        repeat (3) send_request(rwds_pkg::ACT_REPORT, 16'sd0, 16'h0,
                                7'($urandom_range(0, 7)));
        req_ch.valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge i_clk);
        repeat (4) begin
            random_walk_step();
            send_request(rwds_pkg::ACT_REPORT, 16'sd0, 16'h0, 7'($urandom_range(0, 7)));
        end
    endtask

    // sequence of tests
    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = rwds_pkg::CFG_STEPS_PER_WALK;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.action = rwds_pkg::ACT_WALK;
        req_ch.polar_cosine = '0;
        req_ch.azimuth_phase = '0;
        req_ch.report_step = '0;
        res_ch.ready = 1'b0;
        stall_left = 0;
        fail_count = 0;
        mismatch_count = 0;
        mdl_steps_cfg = 100;
        mdl_walks_cfg = 10000;
        walk_x = 0; walk_y = 0; walk_z = 0;
        walk_index = 0;
        for (int i = 0; i < rwds_pkg::MAX_STEPS; i++) begin
            dist_sum[i] = '0;
            dist_sq_sum[i] = '0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset configuration first
        random_walk_step();
        send_request(rwds_pkg::ACT_REPORT, 16'sd0, 16'h0, 7'd0);
        test_directed_fields();
        test_config_extremes();
        test_pressure_holdoff();
        test_random_walks();

        drain_block();
        fail_count += pending_reports.size();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

### random_walk_distance_statistics.f
+incdir+src
src/rwds_pkg.sv
src/rwds_req_if.sv
src/rwds_res_if.sv
src/random_walk_distance_statistics.sv
src/rwds_checker.sv
tb/tb_random_walk_distance_statistics.sv
